### rtl/pidc_pkg.sv
// clamped pid constants: port widths, register indexes, reset values, bounds, step counts
package pidc_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_THR   = 3'd6;

    // reset values of the registers that do not reset to zero
    localparam logic signed [15:0] OUT_MIN_RST   = -16'sd100;
    localparam logic signed [15:0] OUT_MAX_RST   = 16'sd100;
    localparam logic        [16:0] INTEG_LIM_RST = 17'd65535;

    // integral saturation bounds
    localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};

    // serial step counts, loaded as count minus one
    localparam logic [4:0] EP_STEPS_M1  = 5'd15;
    localparam logic [4:0] MUL_STEPS_M1 = 5'd23;
    localparam logic [4:0] DIV_STEPS_M1 = 5'd26;

endpackage

### rtl/pid_controller_clamped.sv
// pid position controller with an integral window and clamped output, bit-serial datapath
//
//  channel   direction  fields (lowest bit up)
//  s_axis    in         measured[15:0] target[31:16] elapsed_ms[47:32]
//  m_axis    out        drive[15:0] finished[16], zero fill to 24 bits
//  cfg       in         write enable, 3-bit index, 32-bit data
//
// a word's result is registered after a serial error-times-time pass, the integral update and
// a restoring divide, then three gain passes; when elapsed_ms is zero only the gain passes run.
// the 16-step error-times-time pass and the three 24-step gain passes share one 72-bit shift-add
// unit, beside the 27-step restoring divider. one word is in work at a time.
// reset is synchronous; it restores register defaults and clears integral, previous error
// and rate. a result waits in the output register, and the next word is accepted meanwhile;
// only a second result stalls while the first is still held.
module pid_controller_clamped (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // measured[15:0], target[31:16], elapsed_ms[47:32]
    input  logic [pidc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive[15:0], finished[16], zero fill [23:17]
    output logic [pidc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_EP, S_INTEG, S_DIV, S_RATE, S_MUL, S_ADD, S_CMP, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        P_ERR, P_INTEG, P_RATE
    } t_pass;

    t_state r_state;
    t_pass  r_pass;

    // configuration
    logic signed [23:0] r_prop_gain;
    logic signed [23:0] r_integ_gain;
    logic signed [23:0] r_deriv_gain;
    logic signed [15:0] r_out_min;
    logic signed [15:0] r_out_max;
    logic        [16:0] r_integ_lim;
    logic signed [31:0] r_done_thr;

    // controller state
    logic signed [47:0] r_integ;
    logic signed [16:0] r_prev_err;
    logic signed [27:0] r_rate;

    // per-word working registers
    logic signed [16:0] r_err;
    logic signed [17:0] r_diff;
    logic        [15:0] r_elapsed;
    logic signed [71:0] r_prod;
    logic        [23:0] r_mplr;
    logic               r_msb_neg;
    logic        [4:0]  r_cnt;
    logic        [15:0] r_rem;
    logic        [26:0] r_dvd;
    logic               r_rate_neg;
    logic signed [71:0] r_sum;
    logic               r_lt_min;

    // output register
    logic               r_out_valid;
    logic        [15:0] r_out_drive;
    logic               r_out_fin;

    logic signed [15:0] in_meas;
    logic signed [15:0] in_tgt;
    logic        [15:0] in_elapsed;
    logic signed [16:0] err_in;
    logic signed [17:0] diff_in;

    logic signed [71:0] mcand;
    logic signed [71:0] addend;
    logic signed [71:0] n_prod;

    logic        [16:0] err_mag;
    logic signed [32:0] ep;
    logic signed [48:0] integ_sum;
    logic signed [47:0] n_integ;

    logic signed [27:0] dx;
    logic signed [27:0] d1000;
    logic signed [27:0] d1000_neg;
    logic        [26:0] dmag;

    logic        [17:0] trial;
    logic        [15:0] n_rem;
    logic               n_qbit;
    logic signed [27:0] n_rate;

    logic signed [59:0] scaled;
    logic signed [59:0] min_ext;
    logic signed [59:0] max_ext;
    logic               gt_max;
    logic        [15:0] drive;
    logic signed [31:0] rate_ext;
    logic               fin;
    logic               out_free;

    assign in_meas    = s_axis_tdata[15:0];
    assign in_tgt     = s_axis_tdata[31:16];
    assign in_elapsed = s_axis_tdata[47:32];
    assign err_in     = {in_tgt[15], in_tgt} - {in_meas[15], in_meas};
    assign diff_in    = {err_in[16], err_in} - {r_prev_err[16], r_prev_err};

    // shared shift-add multiplier, multiplier bits taken msb first
    always_comb begin
        case (r_pass)
            P_ERR:   mcand = {{55{r_err[16]}}, r_err};
            P_INTEG: mcand = {{24{r_integ[47]}}, r_integ};
            P_RATE:  mcand = {{44{r_rate[27]}}, r_rate};
            default: mcand = '0;
        endcase
    end

    assign addend = r_mplr[23] ? mcand : '0;
    // the sign bit of a two's complement gain carries negative weight
    assign n_prod = (r_prod <<< 1) + (r_msb_neg ? -addend : addend);

    // integral update with saturation
    assign err_mag   = r_err[16] ? 17'(-r_err) : 17'(r_err);
    assign ep        = r_prod[32:0];
    assign integ_sum = {r_integ[47], r_integ} + {{16{ep[32]}}, ep};
    always_comb begin
        if (integ_sum[48] != integ_sum[47]) begin
            n_integ = integ_sum[48] ? pidc_pkg::INTEG_MIN : pidc_pkg::INTEG_MAX;
        end else begin
            n_integ = integ_sum[47:0];
        end
    end

    // error difference times 1000 as 1024 - 16 - 8
    assign dx        = {{10{r_diff[17]}}, r_diff};
    assign d1000     = (dx <<< 10) - (dx <<< 4) - (dx <<< 3);
    assign d1000_neg = -d1000;
    assign dmag      = d1000[27] ? d1000_neg[26:0] : d1000[26:0];

    // restoring divider, one quotient bit a cycle
    assign trial  = {1'b0, r_rem, r_dvd[26]} - {2'b00, r_elapsed};
    assign n_qbit = ~trial[17];
    assign n_rem  = n_qbit ? trial[15:0] : {r_rem[14:0], r_dvd[26]};
    assign n_rate = r_rate_neg ? -{1'b0, r_dvd} : {1'b0, r_dvd};

    // floor scaling is a plain drop of the fraction bits
    assign scaled   = r_sum[71:12];
    assign min_ext  = {{44{r_out_min[15]}}, r_out_min};
    assign max_ext  = {{44{r_out_max[15]}}, r_out_max};
    assign gt_max   = scaled > max_ext;
    assign drive    = r_lt_min ? r_out_min : (gt_max ? r_out_max : scaled[15:0]);
    assign rate_ext = {{4{r_rate[27]}}, r_rate};
    assign fin      = rate_ext <= r_done_thr;
    assign out_free = ~r_out_valid | m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_fin, r_out_drive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_out_min    <= pidc_pkg::OUT_MIN_RST;
            r_out_max    <= pidc_pkg::OUT_MAX_RST;
            r_integ_lim  <= pidc_pkg::INTEG_LIM_RST;
            r_done_thr   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidc_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[23:0];
                pidc_pkg::CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[23:0];
                pidc_pkg::CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[23:0];
                pidc_pkg::CFG_OUT_MIN:    r_out_min    <= i_cfg_data[15:0];
                pidc_pkg::CFG_OUT_MAX:    r_out_max    <= i_cfg_data[15:0];
                pidc_pkg::CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data[16:0];
                pidc_pkg::CFG_DONE_THR:   r_done_thr   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= P_ERR;
            r_integ     <= '0;
            r_prev_err  <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the output stage refills the register itself
            if (m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err      <= err_in;
                        r_diff     <= diff_in;
                        r_prev_err <= err_in;
                        r_elapsed  <= in_elapsed;
                        r_prod     <= '0;
                        r_mplr     <= {in_elapsed, 8'b0};
                        r_msb_neg  <= 1'b0;
                        r_cnt      <= pidc_pkg::EP_STEPS_M1;
                        r_pass     <= P_ERR;
                        r_state    <= (in_elapsed == '0) ? S_RATE : S_EP;
                    end
                end
                S_EP: begin
                    r_prod <= n_prod;
                    r_mplr <= {r_mplr[22:0], 1'b0};
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (err_mag < r_integ_lim) begin
                        r_integ <= n_integ;
                    end
                    r_rem      <= '0;
                    r_dvd      <= dmag;
                    r_rate_neg <= d1000[27];
                    r_cnt      <= pidc_pkg::DIV_STEPS_M1;
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[25:0], n_qbit};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    r_rate    <= (r_elapsed == '0) ? '0 : n_rate;
                    r_prod    <= '0;
                    r_sum     <= '0;
                    r_mplr    <= r_prop_gain;
                    r_msb_neg <= 1'b1;
                    r_cnt     <= pidc_pkg::MUL_STEPS_M1;
                    r_pass    <= P_ERR;
                    r_state   <= S_MUL;
                end
                S_MUL: begin
                    r_prod    <= n_prod;
                    r_mplr    <= {r_mplr[22:0], 1'b0};
                    r_msb_neg <= 1'b0;
                    r_cnt     <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sum     <= r_sum + r_prod;
                    r_prod    <= '0;
                    r_msb_neg <= 1'b1;
                    r_cnt     <= pidc_pkg::MUL_STEPS_M1;
                    case (r_pass)
                        P_ERR: begin
                            r_pass  <= P_INTEG;
                            r_mplr  <= r_integ_gain;
                            r_state <= S_MUL;
                        end
                        P_INTEG: begin
                            r_pass  <= P_RATE;
                            r_mplr  <= r_deriv_gain;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_state <= S_CMP;
                        end
                    endcase
                end
                S_CMP: begin
                    r_lt_min <= scaled < min_ext;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_drive <= drive;
                        r_out_fin   <= fin;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/pidc_checker.sv
// port-level checks for the clamped pid controller, bound to the top level
module pidc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pidc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // the engine leaves idle at once after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after a word was taken");

    // a fresh result coincides with the engine going idle
    a_result_frees_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
        else $error("result appeared without the engine returning to idle");

    // ready to take a word straight out of reset
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
